FILE: src/calendar_slot_image_index_macros.svh
// Assertion macros shared by the calendar slot image index RTL.
// Used by calendar_slot_image_index.sv; expects clk and rst in scope.
`ifndef CALENDAR_SLOT_IMAGE_INDEX_MACROS_SVH
`define CALENDAR_SLOT_IMAGE_INDEX_MACROS_SVH
`ifndef SYNTHESIS
`define CSII_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CSII_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSII_ASSERT(name, prop, msg)
`define CSII_ASSERT_RST(name, prop, msg)
`endif
`endif

FILE: src/csii_pkg.sv
// Shared types, constants and small tables for the calendar slot image index.
// No dependencies.
package csii_pkg;

  localparam int unsigned YEAR_MIN    = 1970;
  localparam int unsigned YEAR_MAX    = 9999;
  localparam int unsigned MAX_CUSTOM  = 1023;
  localparam int unsigned DAYS_PER_ERA = 146097;
  // floor(x * RECIP_400 / 2**21) is x / 400, low by at most one for 14-bit x.
  localparam int unsigned RECIP_400   = 5243;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned SLOT_W      = 29;
  localparam int unsigned DAY_W       = 23;
  localparam int unsigned CC_W        = 10;

  typedef enum logic [1:0] {
    REG_CUSTOM_COUNT = 2'd0,
    REG_BUILTIN_COUNT = 2'd1,
    REG_ROTATION     = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic       ok;
    logic       custom;
    logic [7:0] builtin;
  } side_t;

  // Day of year of the first of each month, with the year starting in March.
  function automatic logic [8:0] doy_start(input logic [3:0] mp);
    logic [8:0] r;
    begin
      unique case (mp)
        4'd0: r = 9'd0;
        4'd1: r = 9'd31;
        4'd2: r = 9'd61;
        4'd3: r = 9'd92;
        4'd4: r = 9'd122;
        4'd5: r = 9'd153;
        4'd6: r = 9'd184;
        4'd7: r = 9'd214;
        4'd8: r = 9'd245;
        4'd9: r = 9'd275;
        4'd10: r = 9'd306;
        4'd11: r = 9'd337;
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
        4'd2: r = leap ? 5'd29 : 5'd28;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: src/csii_mod.sv
// Pipelined restoring remainder unit: one quotient bit per register stage.
// Depends on csii_pkg for widths and the sideband struct.
module csii_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [csii_pkg::SLOT_W-1:0] in_num,
  input  csii_pkg::side_t             in_side,
  input  logic [csii_pkg::CC_W-1:0]   divisor,
  output logic                        out_valid,
  output logic [csii_pkg::CC_W-1:0]   out_rem,
  output csii_pkg::side_t             out_side
);

  localparam int unsigned N = csii_pkg::SLOT_W;
  localparam int unsigned W = csii_pkg::CC_W;

  logic [N-1:0]    v;
  logic [N-1:0]    num      [N];
  logic [W-1:0]    rem      [N];
  csii_pkg::side_t side     [N];
  logic [N-1:0]    num_next [N];
  logic [W-1:0]    rem_next [N];
  logic [N-1:0]    v_src;
  csii_pkg::side_t side_src [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [N-1:0] n_src;
      logic [W-1:0] r_src;
      logic [W:0]   t;
      if (k == 0) begin
        n_src = in_num;
        r_src = '0;
        v_src[k] = in_valid;
        side_src[k] = in_side;
      end else begin
        n_src = num[k-1];
        r_src = rem[k-1];
        v_src[k] = v[k-1];
        side_src[k] = side[k-1];
      end
      t = {r_src, n_src[N-1]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      rem_next[k] = t[W-1:0];
      num_next[k] = {n_src[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= v_src;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        num[k]  <= num_next[k];
        rem[k]  <= rem_next[k];
        side[k] <= side_src[k];
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_rem   = rem[N-1];
  assign out_side  = side[N-1];

endmodule

FILE: src/calendar_slot_image_index.sv
// Top level of the calendar slot image index: date checks, day number, slot
// count and the remainder pipeline. Depends on csii_pkg, csii_mod and the macros.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   s_tdata[39:0] date, time, weekday
//  m_*       out        m_tvalid / m_tready   m_tdata[23:0] ok, flags, picks
//  cfg_*     in         cfg_we                cfg_index, cfg_data
//
// One item per cycle unless the output stalls; the pipeline is 5 calendar stages plus 29 remainder stages.
// The remainder unit, one quotient bit per stage, sets the depth.
// Reset (rst, synchronous) empties every stage and restores the registers.
// A stall at the output freezes the whole pipeline; nothing is dropped.
`include "calendar_slot_image_index_macros.svh"
module calendar_slot_image_index (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] weekday[36:34]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok[0] uses_custom[1] builtin_pick[9:2] image_pick[19:10]
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic [9:0]  custom_count;
  logic [7:0]  builtin_count;
  logic [10:0] rotation_minutes;

  always_ff @(posedge clk) begin
    if (rst) begin
      custom_count     <= 10'd0;
      builtin_count    <= 8'd1;
      rotation_minutes <= 11'd1440;
    end else if (cfg_we) begin
      unique case (csii_pkg::cfg_reg_t'(cfg_index))
        csii_pkg::REG_CUSTOM_COUNT:  custom_count     <= cfg_data[9:0];
        csii_pkg::REG_BUILTIN_COUNT: builtin_count    <= cfg_data[7:0];
        csii_pkg::REG_ROTATION:      rotation_minutes <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic dv_valid;
  logic [9:0] dv_rem;
  csii_pkg::side_t dv_side;

  assign adv      = !dv_valid || m_tready;
  assign s_tready = adv;

  // Stage A: field checks, configuration checks, builtin pick, /400 products.
  logic [13:0] y_in, yy_in;
  logic [3:0]  m_in, mp_in;
  logic [4:0]  d_in, h_in;
  logic [5:0]  mi_in;
  logic [2:0]  wd_in;
  logic        ok_a_in, rot_ok;
  logic [5:0]  slots_in, minpart_in;
  logic [10:0] h43;
  logic [7:0]  bpick_in;

  assign y_in  = s_tdata[13:0];
  assign m_in  = s_tdata[17:14];
  assign d_in  = s_tdata[22:18];
  assign h_in  = s_tdata[27:23];
  assign mi_in = s_tdata[33:28];
  assign wd_in = s_tdata[36:34];
  assign h43   = 11'(h_in) * 11'd43;

  always_comb begin
    logic [8:0] r;
    yy_in = (m_in <= 4'd2) ? y_in - 14'd1 : y_in;
    mp_in = (m_in > 4'd2) ? m_in - 4'd3 : m_in + 4'd9;
    rot_ok = 1'b1;
    unique case (rotation_minutes)
      11'd30: begin
        slots_in = 6'd48;
        minpart_in = {h_in, 1'b0} + 6'(mi_in >= 6'd30);
      end
      11'd60: begin
        slots_in = 6'd24;
        minpart_in = 6'(h_in);
      end
      11'd360: begin
        slots_in = 6'd4;
        minpart_in = 6'(h43[10:8]);
      end
      11'd720: begin
        slots_in = 6'd2;
        minpart_in = 6'(h_in >= 5'd12);
      end
      11'd1440: begin
        slots_in = 6'd1;
        minpart_in = 6'd0;
      end
      default: begin
        slots_in = 6'd0;
        minpart_in = 6'd0;
        rot_ok = 1'b0;
      end
    endcase
    // Weekday is three bits, so the remainder takes three restoring steps.
    r = '0;
    for (int i = 2; i >= 0; i--) begin
      r = {r[7:0], wd_in[i]};
      if (r >= {1'b0, builtin_count}) begin
        r = r - {1'b0, builtin_count};
      end
    end
    bpick_in = r[7:0];
    ok_a_in = (y_in >= 14'(csii_pkg::YEAR_MIN)) && (y_in <= 14'(csii_pkg::YEAR_MAX)) &&
              (m_in >= 4'd1) && (m_in <= 4'd12) && (d_in >= 5'd1) &&
              (h_in < 5'd24) && (mi_in < 6'd60) && (wd_in < 3'd7) && rot_ok &&
              (32'(custom_count) <= csii_pkg::MAX_CUSTOM) && (builtin_count != 8'd0);
  end

  logic        va, ok_a;
  logic [13:0] y_a, yy_a;
  logic [3:0]  m_a, mp_a;
  logic [4:0]  d_a;
  logic [5:0]  slots_a, minpart_a;
  logic [7:0]  bpick_a;
  logic [26:0] py_a, pyy_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_a <= ok_a_in; y_a <= y_in; yy_a <= yy_in; m_a <= m_in; mp_a <= mp_in;
      d_a <= d_in; slots_a <= slots_in; minpart_a <= minpart_in; bpick_a <= bpick_in;
      py_a  <= 27'(y_in) * 27'(csii_pkg::RECIP_400);
      pyy_a <= 27'(yy_in) * 27'(csii_pkg::RECIP_400);
    end
  end

  // Stage B: remainders by 400 with one correction step, day of year.
  logic [13:0] ry_b_in, ryy_b_in;
  logic [5:0]  ey_b_in, eyy_b_in;
  always_comb begin
    ey_b_in  = py_a[26:csii_pkg::RECIP_SHIFT];
    eyy_b_in = pyy_a[26:csii_pkg::RECIP_SHIFT];
    ry_b_in  = y_a - 14'(ey_b_in * 14'd400);
    ryy_b_in = yy_a - 14'(eyy_b_in * 14'd400);
    if (ry_b_in >= 14'd400) begin
      ry_b_in = ry_b_in - 14'd400;
    end
    if (ryy_b_in >= 14'd400) begin
      ryy_b_in = ryy_b_in - 14'd400;
      eyy_b_in = eyy_b_in + 6'd1;
    end
  end

  logic        vb, ok_b;
  logic [1:0]  ylo_b;
  logic [8:0]  ry_b, yoe_b, doyd_b;
  logic [5:0]  era_b, slots_b, minpart_b;
  logic [3:0]  m_b;
  logic [4:0]  d_b;
  logic [7:0]  bpick_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_b <= ok_a; ylo_b <= y_a[1:0]; ry_b <= ry_b_in[8:0]; yoe_b <= ryy_b_in[8:0];
      era_b <= eyy_b_in; m_b <= m_a; d_b <= d_a; slots_b <= slots_a;
      minpart_b <= minpart_a; bpick_b <= bpick_a;
      doyd_b <= csii_pkg::doy_start(mp_a) + 9'(d_a) - 9'd1;
    end
  end

  // Stage C: leap year, month length check, day of era.
  logic        leap_c;
  logic [14:0] y41_c;
  logic [17:0] doe_c_in;
  assign leap_c = (ylo_b == 2'd0) && (ry_b != 9'd100) && (ry_b != 9'd200) &&
                  (ry_b != 9'd300);
  assign y41_c  = 15'(yoe_b) * 15'd41;
  assign doe_c_in = 18'(yoe_b) * 18'd365 + 18'(yoe_b[8:2]) - 18'(y41_c[14:12]) +
                    18'(doyd_b);

  logic        vc, ok_c;
  logic [17:0] doe_c;
  logic [5:0]  era_c, slots_c, minpart_c;
  logic [7:0]  bpick_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_c <= ok_b && (d_b <= csii_pkg::month_len(m_b, leap_c));
      doe_c <= doe_c_in; era_c <= era_b; slots_c <= slots_b;
      minpart_c <= minpart_b; bpick_c <= bpick_b;
    end
  end

  // Stage D: day number.
  logic        vd, ok_d;
  logic [csii_pkg::DAY_W-1:0] day_d;
  logic [5:0]  slots_d, minpart_d;
  logic [7:0]  bpick_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok_d <= ok_c;
      day_d <= csii_pkg::DAY_W'(era_c) * csii_pkg::DAY_W'(csii_pkg::DAYS_PER_ERA) +
               csii_pkg::DAY_W'(doe_c);
      slots_d <= slots_c; minpart_d <= minpart_c; bpick_d <= bpick_c;
    end
  end

  // Stage E: slot number; invalid items have their flags and picks cleared.
  logic        ve;
  logic [csii_pkg::SLOT_W-1:0] slot_e;
  csii_pkg::side_t side_e;

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_e <= csii_pkg::SLOT_W'(day_d) * csii_pkg::SLOT_W'(slots_d) +
                csii_pkg::SLOT_W'(minpart_d);
      side_e.ok      <= ok_d;
      side_e.custom  <= ok_d && (custom_count != 10'd0);
      side_e.builtin <= ok_d ? bpick_d : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd, ve} <= '0;
    end else if (adv) begin
      {va, vb, vc, vd, ve} <= {s_tvalid, va, vb, vc, vd};
    end
  end

  csii_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (ve),
    .in_num    (slot_e),
    .in_side   (side_e),
    .divisor   (custom_count),
    .out_valid (dv_valid),
    .out_rem   (dv_rem),
    .out_side  (dv_side)
  );

  logic [9:0] image_pick;
  assign image_pick = dv_side.custom ? dv_rem : 10'(dv_side.builtin);
  assign m_tvalid = dv_valid;
  assign m_tdata  = {4'd0, image_pick, dv_side.builtin, dv_side.custom, dv_side.ok};

  `CSII_ASSERT(a_bad_clears, m_tvalid && !m_tdata[0] |-> m_tdata[19:1] == 19'd0, "invalid result not cleared")
  `CSII_ASSERT(a_custom_range, m_tvalid && m_tdata[1] |-> m_tdata[19:10] < custom_count, "custom pick out of range")
  `CSII_ASSERT(a_builtin_range, m_tvalid && m_tdata[0] |-> m_tdata[9:2] < builtin_count, "builtin pick out of range")
  `CSII_ASSERT_RST(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for calendar_slot_image_index: date checks and image picks.
// Depends on csii_pkg and the block's RTL; predicts every result in the bench itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } slot_query_t;

  typedef struct packed {
    logic [9:0] image_pick;
    logic [7:0] builtin_pick;
    logic       uses_custom;
    logic       ok;
  } slot_pick_t;

  localparam int PIPE_DEPTH = 34;
  localparam int IDLE_LIMIT = 2000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_we;
  csii_pkg::cfg_reg_t cfg_index;
  logic [10:0] cfg_data;

  logic [9:0]  custom_count;
  logic [7:0]  builtin_count;
  logic [10:0] rotation_minutes;

  slot_pick_t  pending_picks[$];
  int          error_count;
  int          idle_cycles;
  bit          hold_off;

  calendar_slot_image_index dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_span(int unsigned y, int unsigned m);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    if (m == 2 && is_leap(y)) return 29;
    return lens[m - 1];
  endfunction

  // Day count from 0000-03-01, counted in 400-year eras.
  function automatic longint unsigned civil_days(int unsigned y, int unsigned m,
                                                 int unsigned d);
    int unsigned yy, era, yoe, mp, doy, doe;
    yy = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * 146097 + doe;
  endfunction

  function automatic slot_pick_t predict_pick(slot_query_t q);
    slot_pick_t p;
    bit ok;
    int unsigned rot;
    longint unsigned slot;
    rot = rotation_minutes;
    ok = q.year >= 1970 && q.year <= 9999 && q.day >= 1 &&
         q.day <= month_span(q.year, q.month) && q.hour < 24 && q.minute < 60 &&
         (rot == 30 || rot == 60 || rot == 360 || rot == 720 || rot == 1440) &&
         q.weekday < 7 && custom_count <= csii_pkg::MAX_CUSTOM && builtin_count > 0;
    p = '0;
    if (ok) begin
      p.ok = 1'b1;
      p.builtin_pick = 8'(q.weekday % builtin_count);
      p.image_pick = 10'(p.builtin_pick);
      if (custom_count != 0) begin
        p.uses_custom = 1'b1;
        slot = civil_days(q.year, q.month, q.day) * (1440 / rot) +
               (q.hour * 60 + q.minute) / rot;
        p.image_pick = 10'(slot % custom_count);
      end
    end
    return p;
  endfunction

  // Keeps tvalid high across back-to-back transfers; drops it only for a gap.
  task automatic send_query(slot_query_t q);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, q};
    pending_picks.push_back(predict_pick(q));
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every result is back, then lets the pipeline drain.
  task automatic settle;
    s_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_reg(csii_pkg::cfg_reg_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 11'(value);
    @(posedge clk);
    case (idx)
      csii_pkg::REG_CUSTOM_COUNT:  custom_count = 10'(value);
      csii_pkg::REG_BUILTIN_COUNT: builtin_count = 8'(value);
      csii_pkg::REG_ROTATION:      rotation_minutes = 11'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned cc, int unsigned bc, int unsigned rot);
    settle();
    write_reg(csii_pkg::REG_CUSTOM_COUNT, cc);
    write_reg(csii_pkg::REG_BUILTIN_COUNT, bc);
    write_reg(csii_pkg::REG_ROTATION, rot);
    cfg_we <= 1'b0;
  endtask

  function automatic slot_query_t make_query(int unsigned y, int unsigned m,
      int unsigned d, int unsigned h, int unsigned mi, int unsigned wd);
    slot_query_t q;
    q.year = 14'(y); q.month = 4'(m); q.day = 5'(d);
    q.hour = 5'(h); q.minute = 6'(mi); q.weekday = 3'(wd);
    return q;
  endfunction

  function automatic slot_query_t random_query();
    slot_query_t q;
    q = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      q.year = 14'($urandom_range(1970, 9999));
      q.month = 4'($urandom_range(1, 12));
      q.day = 5'($urandom_range(1, month_span(q.year, q.month)));
      q.hour = 5'($urandom_range(0, 23));
      q.minute = 6'($urandom_range(0, 59));
      q.weekday = 3'($urandom_range(0, 6));
    end
    return q;
  endfunction

  task automatic test_directed;
    set_config(1023, 255, 30);
    send_query(make_query(1970, 1, 1, 0, 0, 0));
    send_query(make_query(9999, 12, 31, 23, 59, 6));
    send_query(make_query(2000, 2, 29, 12, 30, 3));
    send_query(make_query(1900 + 100, 2, 30, 1, 1, 1));
    send_query(make_query(2100, 2, 29, 1, 1, 1));
    send_query(make_query(2024, 2, 29, 1, 1, 1));
    send_query(make_query(1969, 6, 1, 0, 0, 0));
    send_query(make_query(10000, 6, 1, 0, 0, 0));
    send_query(make_query(16383, 15, 31, 31, 63, 7));
    send_query(make_query(0, 0, 0, 0, 0, 0));
    send_query(make_query(2020, 13, 1, 0, 0, 0));
    send_query(make_query(2020, 4, 31, 0, 0, 0));
    send_query(make_query(2020, 4, 0, 0, 0, 0));
    send_query(make_query(2020, 4, 30, 24, 0, 0));
    send_query(make_query(2020, 4, 30, 0, 60, 0));
    send_query(make_query(2020, 4, 30, 0, 0, 7));
    set_config(0, 0, 1440);
    send_query(make_query(2020, 5, 5, 5, 5, 5));
    set_config(5, 3, 45);
    send_query(make_query(2020, 5, 5, 5, 5, 5));
    set_config(0, 4, 0);
    send_query(make_query(2020, 5, 5, 5, 5, 6));
    set_config(1, 1, 2047);
    send_query(make_query(2020, 5, 5, 5, 5, 6));
  endtask

  task automatic test_random(int n, int unsigned cc, int unsigned bc, int unsigned rot);
    set_config(cc, bc, rot);
    repeat (n) send_query(random_query());
  endtask

  // The receiver stalls while the sender keeps offering, filling the pipeline.
  task automatic test_backpressure;
    set_config(997, 7, 60);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (60) send_query(random_query());
    join
  endtask

  // The receiver waits a random number of cycles before each transfer.
  always begin : receiver
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0 || hold_off) begin
      m_tready <= 1'b0;
      repeat (gap) @(posedge clk);
      while (hold_off) @(posedge clk);
    end
    m_tready <= 1'b1;
    do @(posedge clk); while (!(m_tvalid && m_tready));
  end

  always @(posedge clk) begin
    slot_pick_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[19:0];
      if (pending_picks.size() == 0) begin
        $display("%0t: result with none pending: %h", $time, got);
        error_count++;
      end else begin
        want = pending_picks.pop_front();
        if (got.ok !== want.ok || got.uses_custom !== want.uses_custom ||
            got.builtin_pick !== want.builtin_pick || got.image_pick !== want.image_pick) begin
          $display(
            "%0t: mismatch expected ok=%0d cu=%0d b=%0d i=%0d got ok=%0d cu=%0d b=%0d i=%0d",
            $time, want.ok, want.uses_custom, want.builtin_pick, want.image_pick,
            got.ok, got.uses_custom, got.builtin_pick, got.image_pick);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = csii_pkg::REG_CUSTOM_COUNT;
    cfg_data = '0;
    hold_off = 1'b0;
    idle_cycles = 0;
    error_count = 0;
    custom_count = 10'd0;
    builtin_count = 8'd1;
    rotation_minutes = 11'd1440;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_random(20, 0, 1, 1440);
    test_directed();
    test_random(120, 1023, 255, 30);
    test_random(100, $urandom_range(1, 1022), $urandom_range(1, 254), 360);
    test_random(80, 1, 7, 720);
    test_backpressure();
    test_random(100, $urandom_range(2, 200), 1, 60);
    test_random(30, 0, 255, 1440);
    settle();
    if (error_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
